// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/stfp_pkg.sv -----
// ---------------------------------------------------------------------------
// stfp_pkg
// Types and constants shared by the sensor text frame parser.
// ---------------------------------------------------------------------------
package stfp_pkg;

  localparam int unsigned WinLen = 14;
  localparam int unsigned NumFields = 7;
  localparam int unsigned NumKeys = 8;

  localparam logic [7:0] ChNl    = 8'd10;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChColon = 8'd58;
  localparam logic [7:0] ChPlus  = 8'd43;
  localparam logic [7:0] ChMinus = 8'd45;
  localparam logic [7:0] ChZero  = 8'd48;
  localparam logic [7:0] ChLowX  = 8'd120;
  localparam logic [7:0] ChUpX   = 8'd88;

  // marker text, first character in the top byte
  localparam logic [WinLen*8-1:0] StartMark = {"--[new", "_line]--"};
  localparam logic [WinLen*8-1:0] StopMark  = {"--[end", "_line]--"};

  // key texts, right aligned in the window compare
  localparam logic [WinLen*8-1:0] KeyText [NumKeys] = '{
    {88'd0, "CRC"}, {64'd0, "PM 1.0"}, {64'd0, "PM 2.5"}, {56'd0, "PM 10.0"},
    {40'd0, "CO2 Level"}, {24'd0, "Temperature"}, {48'd0, "Humidity"},
    {24'd0, "Radiation: "}
  };
  localparam logic [3:0] KeyLen [NumKeys] = '{
    4'd3, 4'd6, 4'd6, 4'd7, 4'd9, 4'd11, 4'd8, 4'd11
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_end;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pm_one;
    logic signed [31:0] pm_two_five;
    logic signed [31:0] pm_ten;
    logic signed [31:0] co2_level;
    logic signed [31:0] temperature;
    logic signed [31:0] humidity;
    logic signed [31:0] radiation;
    logic [15:0]        received_sum;
    logic               sum_matches;
    logic               record_accepted;
  } out_item_t;

  typedef enum logic [1:0] {
    LineNone,
    LineStart,
    LineStop,
    LineData
  } line_kind_e;

  // one finished line, handed from the scanner to the record stage
  typedef struct packed {
    logic               valid;
    line_kind_e         kind;
    logic               is_crc;
    logic               crc_ok;
    logic [15:0]        crc_val;
    logic               dec_ok;
    logic [2:0]         field;
    logic               has_field;
    logic signed [31:0] dec_val;
    logic               chunk_end;
  } line_evt_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= 8'd48 && c <= 8'd57) begin
      t = c - 8'd48;
      return {1'b1, t[3:0]};
    end else if (c >= 8'd97 && c <= 8'd102) begin
      t = c - 8'd87;
      return {1'b1, t[3:0]};
    end else if (c >= 8'd65 && c <= 8'd70) begin
      t = c - 8'd55;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

// ----- src/stfp_line_scan.sv -----
// ---------------------------------------------------------------------------
// stfp_line_scan
// Front part: shifts bytes into the line window, tracks keys, separator and
// the decimal and hex readings, and emits one event per finished line.
// ---------------------------------------------------------------------------
module stfp_line_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  stfp_pkg::in_item_t  in_item_i,
  input  logic                stopped_i,
  output stfp_pkg::line_evt_t evt_o
);

  localparam int unsigned WinBits = stfp_pkg::WinLen * 8;

  typedef enum logic [2:0] {
    DecWs, DecSign, DecDigits, DecDone, DecBad
  } dec_phase_e;

  typedef enum logic [2:0] {
    HexWs, HexSign, HexZero, HexPrefix, HexDigits, HexEnd, HexBad
  } hex_phase_e;

  logic [WinBits-1:0] win_q, win_d;
  logic [4:0]         len_q, len_d;
  logic [7:0]         keys_q, keys_d;
  logic               sep_q, sep_d;
  dec_phase_e         dph_q, dph_d;
  logic [32:0]        dacc_q, dacc_d;
  logic               derr_q, derr_d;
  logic               dneg_q, dneg_d;
  hex_phase_e         hph_q, hph_d;
  logic [15:0]        hacc_q, hacc_d;
  logic [4:0]         hcnt_q, hcnt_d;
  logic               hneg_q, hneg_d;

  logic [7:0]   c;
  logic [4:0]   hv;
  logic [36:0]  dmul;
  logic         fin;
  logic [WinBits-1:0] wfin;
  logic [4:0]   lfin;
  logic [7:0]   kfin;
  logic         sfin, dokf, hokf, dnegf, hnegf;
  dec_phase_e   dphf;
  hex_phase_e   hphf;
  logic [32:0]  daccf;
  logic         derrf;
  logic [15:0]  haccf;
  logic [4:0]   hcntf;
  logic [31:0]  dv;
  stfp_pkg::line_evt_t evt_d;

  function automatic logic win_match(input logic [WinBits-1:0] w, input logic [4:0] l,
                                     input int unsigned k);
    logic [WinBits-1:0] mask;
    mask = '0;
    for (int i = 0; i < int'(stfp_pkg::WinLen); i++) begin
      if (i < int'(stfp_pkg::KeyLen[k])) mask[i*8 +: 8] = 8'hFF;
    end
    return (l >= {1'b0, stfp_pkg::KeyLen[k]}) &&
           ((w & mask) == stfp_pkg::KeyText[k]);
  endfunction

  assign c  = in_item_i.data_byte;
  assign hv = stfp_pkg::hex_val(c);

  always_comb begin
    win_d = win_q; len_d = len_q; keys_d = keys_q; sep_d = sep_q;
    dph_d = dph_q; dacc_d = dacc_q; derr_d = derr_q; dneg_d = dneg_q;
    hph_d = hph_q; hacc_d = hacc_q; hcnt_d = hcnt_q; hneg_d = hneg_q;
    fin = 1'b0;
    dmul = 37'd0;
    if (in_valid_i && !stopped_i) begin
      if (c == stfp_pkg::ChNl) begin
        fin = 1'b1;
      end else begin
        win_d = {win_q[WinBits-9:0], c};
        if (len_q != 5'd31) len_d = len_q + 5'd1;
        if (sep_q) begin
          dmul = {4'd0, dacc_q} * 37'd10 + {29'd0, c - stfp_pkg::ChZero};
          unique case (dph_q)
            DecWs: begin
              if (stfp_pkg::is_ws(c)) begin
              end else if (c == stfp_pkg::ChPlus || c == stfp_pkg::ChMinus) begin
                dneg_d = (c == stfp_pkg::ChMinus); dph_d = DecSign;
              end else if (stfp_pkg::is_dec(c)) begin
                dacc_d = dmul[32:0]; dph_d = DecDigits;
              end else dph_d = DecBad;
            end
            DecSign: begin
              if (stfp_pkg::is_dec(c)) begin
                dacc_d = dmul[32:0]; dph_d = DecDigits;
              end else dph_d = DecBad;
            end
            DecDigits: begin
              if (stfp_pkg::is_dec(c)) begin
                if (!derr_q) begin
                  dacc_d = dmul[32:0];
                  if (dmul > 37'h080000000) derr_d = 1'b1;
                end
              end else dph_d = DecDone;
            end
            default: ;
          endcase
          unique case (hph_q)
            HexWs, HexSign: begin
              if (hph_q == HexWs && stfp_pkg::is_ws(c)) begin
              end else if (hph_q == HexWs &&
                           (c == stfp_pkg::ChPlus || c == stfp_pkg::ChMinus)) begin
                hneg_d = (c == stfp_pkg::ChMinus); hph_d = HexSign;
              end else if (c == stfp_pkg::ChZero) hph_d = HexZero;
              else if (hv[4]) begin
                if (hcnt_q != 5'd17) hcnt_d = hcnt_q + 5'd1;
                hacc_d = {hacc_q[11:0], hv[3:0]}; hph_d = HexDigits;
              end else hph_d = HexBad;
            end
            HexZero: begin
              if (c == stfp_pkg::ChLowX || c == stfp_pkg::ChUpX) hph_d = HexPrefix;
              else if (hv[4]) begin
                if (hcnt_q != 5'd0 || hv[3:0] != 4'd0) begin
                  if (hcnt_q != 5'd17) hcnt_d = hcnt_q + 5'd1;
                  hacc_d = {hacc_q[11:0], hv[3:0]};
                end
                hph_d = HexDigits;
              end else hph_d = HexEnd;
            end
            HexPrefix, HexDigits: begin
              if (hv[4]) begin
                if (hcnt_q != 5'd0 || hv[3:0] != 4'd0) begin
                  if (hcnt_q != 5'd17) hcnt_d = hcnt_q + 5'd1;
                  hacc_d = {hacc_q[11:0], hv[3:0]};
                end
                hph_d = HexDigits;
              end else hph_d = HexEnd;
            end
            default: ;
          endcase
        end else if (c == stfp_pkg::ChSpace && len_q != 5'd0 &&
                     win_q[7:0] == stfp_pkg::ChColon) begin
          sep_d = 1'b1;
        end
        for (int k = 0; k < int'(stfp_pkg::NumKeys); k++) begin
          if (win_match(win_d, len_d, k)) keys_d[k] = 1'b1;
        end
      end
    end
    // chunk end always clears the line, stopped frame or not
    if (in_valid_i && in_item_i.chunk_end) fin = 1'b1;
    wfin = win_d; lfin = len_d; kfin = keys_d; sfin = sep_d;
    dphf = dph_d; daccf = dacc_d; derrf = derr_d; dnegf = dneg_d;
    hphf = hph_d; haccf = hacc_d; hcntf = hcnt_d; hnegf = hneg_d;
    if (fin) begin
      win_d = '0; len_d = '0; keys_d = '0; sep_d = 1'b0;
      dph_d = DecWs; dacc_d = '0; derr_d = 1'b0; dneg_d = 1'b0;
      hph_d = HexWs; hacc_d = '0; hcnt_d = '0; hneg_d = 1'b0;
    end
  end

  always_comb begin
    evt_d = '0;
    dokf = (dphf == DecDigits || dphf == DecDone) && !derrf &&
           (dnegf || daccf <= 33'h07FFFFFFF);
    hokf = (hphf == HexZero || hphf == HexPrefix || hphf == HexDigits ||
            hphf == HexEnd) && hcntf <= 5'd16;
    dv = dnegf ? (32'd0 - daccf[31:0]) : daccf[31:0];
    evt_d.valid = fin;
    evt_d.chunk_end = in_valid_i && in_item_i.chunk_end;
    if (lfin == 5'd14 && wfin == stfp_pkg::StartMark) evt_d.kind = stfp_pkg::LineStart;
    else if (lfin == 5'd14 && wfin == stfp_pkg::StopMark) evt_d.kind = stfp_pkg::LineStop;
    else if (sfin) evt_d.kind = stfp_pkg::LineData;
    else evt_d.kind = stfp_pkg::LineNone;
    evt_d.is_crc = kfin[0];
    evt_d.crc_ok = hokf;
    evt_d.crc_val = hnegf ? (16'd0 - haccf) : haccf;
    evt_d.dec_ok = dokf;
    evt_d.dec_val = dv;
    evt_d.has_field = |kfin[7:1];
    evt_d.field = 3'd0;
    for (int k = int'(stfp_pkg::NumKeys) - 1; k >= 1; k--) begin
      if (kfin[k]) evt_d.field = 3'(k - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0; len_q <= '0; keys_q <= '0; sep_q <= 1'b0;
      dph_q <= DecWs; dacc_q <= '0; derr_q <= 1'b0; dneg_q <= 1'b0;
      hph_q <= HexWs; hacc_q <= '0; hcnt_q <= '0; hneg_q <= 1'b0;
      evt_o <= '0;
    end else begin
      win_q <= win_d; len_q <= len_d; keys_q <= keys_d; sep_q <= sep_d;
      dph_q <= dph_d; dacc_q <= dacc_d; derr_q <= derr_d; dneg_q <= dneg_d;
      hph_q <= hph_d; hacc_q <= hacc_d; hcnt_q <= hcnt_d; hneg_q <= hneg_d;
      evt_o <= evt_d;
    end
  end

endmodule

// ----- src/stfp_record.sv -----
// ---------------------------------------------------------------------------
// stfp_record
// Back part: applies finished line events to the frame state and builds the
// result record at chunk end.
// ---------------------------------------------------------------------------
module stfp_record (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  stfp_pkg::line_evt_t  evt_i,
  output logic                 stopped_o,
  output logic                 res_valid_o,
  output stfp_pkg::out_item_t  res_o
);

  logic               started_q, stopped_q;
  logic [15:0]        sum_q, crc_q;
  logic signed [31:0] fld_q [stfp_pkg::NumFields];
  logic               st_n, sp_n;
  logic [15:0]        sum_n, crc_n;
  logic signed [31:0] fld_n [stfp_pkg::NumFields];
  stfp_pkg::out_item_t res_d;

  always_comb begin
    st_n = started_q; sp_n = stopped_q; sum_n = sum_q; crc_n = crc_q;
    for (int i = 0; i < int'(stfp_pkg::NumFields); i++) fld_n[i] = fld_q[i];
    if (evt_i.valid && !stopped_q) begin
      unique case (evt_i.kind)
        stfp_pkg::LineStart: st_n = 1'b1;
        stfp_pkg::LineStop:  sp_n = 1'b1;
        stfp_pkg::LineData: begin
          if (started_q) begin
            if (evt_i.is_crc) begin
              if (evt_i.crc_ok) crc_n = evt_i.crc_val;
            end else if (evt_i.has_field && evt_i.dec_ok) begin
              fld_n[evt_i.field] = evt_i.dec_val;
              sum_n = sum_q + evt_i.dec_val[15:0];
            end
          end
        end
        default: ;
      endcase
    end
    res_d.pm_one = fld_n[0];
    res_d.pm_two_five = fld_n[1];
    res_d.pm_ten = fld_n[2];
    res_d.co2_level = fld_n[3];
    res_d.temperature = fld_n[4];
    res_d.humidity = fld_n[5];
    res_d.radiation = fld_n[6];
    res_d.received_sum = crc_n;
    res_d.sum_matches = (sum_n == crc_n);
    res_d.record_accepted = (fld_n[3] != 32'sd0);
  end

  // the frame state clears at the end of this cycle on a chunk end
  assign stopped_o = stopped_q && !evt_i.chunk_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0; stopped_q <= 1'b0; sum_q <= '0; crc_q <= '0;
      for (int i = 0; i < int'(stfp_pkg::NumFields); i++) fld_q[i] <= '0;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= evt_i.chunk_end;
      if (evt_i.chunk_end) begin
        started_q <= 1'b0; stopped_q <= 1'b0; sum_q <= '0; crc_q <= '0;
        for (int i = 0; i < int'(stfp_pkg::NumFields); i++) fld_q[i] <= '0;
      end else begin
        started_q <= st_n; stopped_q <= sp_n; sum_q <= sum_n; crc_q <= crc_n;
        for (int i = 0; i < int'(stfp_pkg::NumFields); i++) fld_q[i] <= fld_n[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.chunk_end) res_o <= res_d;
  end

endmodule

// ----- src/stfp_out_fifo.sv -----
// ---------------------------------------------------------------------------
// stfp_out_fifo
// Result queue between the record stage and the pop side.
// ---------------------------------------------------------------------------
module stfp_out_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  stfp_pkg::out_item_t wdata_i,
  input  logic                rd_i,
  output stfp_pkg::out_item_t rdata_o,
  output logic                empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  stfp_pkg::out_item_t mem_q [Depth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [$clog2(Depth+1)-1:0] cnt_q;

  function automatic logic [Aw-1:0] inc(input logic [Aw-1:0] p);
    return (p == Aw'(Depth - 1)) ? '0 : p + Aw'(1);
  endfunction

  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= inc(wp_q);
      if (rd_i) rp_q <= inc(rp_q);
      if (wr_i && !rd_i) cnt_q <= cnt_q + 1'b1;
      else if (rd_i && !wr_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end

endmodule

// ----- src/sensor_text_frame_parser.sv -----
// An accepted chunk-end byte passes the scanner event register, then the
// record result register. Throughput: one byte per cycle while full is
// low; full rises when stored results plus results still in flight reach
// the queue depth. Reset: asynchronous, active low; all frame and line
// state clears, queue empties.
// ---------------------------------------------------------------------------
// sensor_text_frame_parser
// Line scanner front, record back, and a result queue toward the pop side.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sensor_text_frame_parser #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  stfp_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output stfp_pkg::out_item_t out_item_o
);

  localparam int unsigned Cw = $clog2(QueueDepth + 1);

  stfp_pkg::line_evt_t evt;
  logic                stopped, res_valid, acc, pend_q;
  logic                rd;
  stfp_pkg::out_item_t res;
  logic [Cw-1:0]       cnt;
  logic [Cw+1:0]       used;

  assign acc = push && !full;
  assign rd  = pop && !empty;

  // results in flight: event stage plus record stage
  assign used = {2'b0, cnt} + {{(Cw+1){1'b0}}, pend_q} + {{(Cw+1){1'b0}}, res_valid};
  assign full = used >= (Cw+2)'(QueueDepth);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= 1'b0;
    else pend_q <= acc && in_item_i.chunk_end;
  end

  stfp_line_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (acc),
    .in_item_i  (in_item_i),
    .stopped_i  (stopped),
    .evt_o      (evt)
  );

  stfp_record u_rec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt),
    .stopped_o   (stopped),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  stfp_out_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_valid),
    .wdata_i (res),
    .rd_i    (rd),
    .rdata_o (out_item_o),
    .empty_o (empty),
    .count_o (cnt)
  );

  `ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, res_valid, cnt < Cw'(QueueDepth) || rd)
  `ASSERT_NEXT(a_end_to_evt, clk_i, rst_ni, acc && in_item_i.chunk_end, evt.chunk_end)
  `ASSERT_NEXT(a_evt_to_res, clk_i, rst_ni, evt.chunk_end, res_valid)

endmodule
